@@ src/fflte_pkg.sv @@
// shared types and constants for the fixed-form leader tab expander
package fflte_pkg;

   // fixed field and column widths
   localparam int CHAR_W      = 8;
   localparam int COL_W       = 8;
   localparam int MOD_W       = 3;
   localparam int TAB_STOP    = 6;
   localparam int CONT_COLUMN = 5;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_ONE   = 8'h31;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   // input item
   typedef struct packed {
      logic              action;
      logic [CHAR_W-1:0] char_in;
   } req_type;

   // result item
   typedef struct packed {
      logic [CHAR_W-1:0] char_out;
      logic              char_valid;
      logic              line_end;
      logic              run_overflow;
      logic              last_of_run;
   } rsp_type;

   // line phase
   typedef enum logic [1:0] {
      PH_LEADER  = 2'd0,
      PH_TEXT    = 2'd1,
      PH_PENDING = 2'd2
   } phase_type;

   // source of an emitted result
   typedef enum logic [1:0] {
      EMIT_SPACE = 2'd0,
      EMIT_ITEM  = 2'd1,
      EMIT_BLANK = 2'd2,
      EMIT_END   = 2'd3
   } emit_kind_type;

   // controller to datapath
   typedef struct packed {
      logic          load_item;
      logic          emit;
      emit_kind_type kind;
      logic          last;
      logic          col_inc;
      logic          fto_clr;
      logic          run_push;
      logic          run_restart;
      logic          run_clear;
      logic          flush_start;
      logic          flush_active;
      logic          flush_step;
      logic          line_reset;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_eol;
      logic is_space;
      logic is_tab;
      logic is_digit;
      logic is_digit19;
      logic col_at_max;
      logic col_next_max;
      logic col_lt_cont;
      logic col_lt_stop;
      logic tab_done;
      logic fto;
      logic run_empty;
      logic run_full;
      logic flush_done;
      logic out_free;
   } status_type;

endpackage

@@ src/fflte_datapath.sv @@
// datapath: held item, column tracking, blank run memory and result register
module fflte_datapath import fflte_pkg::*; #(
   parameter int RUN_DEPTH  = 63,
   parameter int COLUMN_MAX = 255
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   input  logic       rsp_stall
);

   localparam int IDX_W = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
   localparam int CNT_W = $clog2(RUN_DEPTH + 1);

   req_type             item_ff;
   logic [COL_W-1:0]    column_ff;
   logic [MOD_W-1:0]    col_mod_ff;
   logic                fto_ff;
   logic [CNT_W-1:0]    run_count_ff;
   logic                overflow_ff;
   logic [IDX_W-1:0]    flush_idx_ff;
   logic                kinds_mem [RUN_DEPTH];
   logic                kinds_rd_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic [IDX_W-1:0]    wr_addr;
   logic                kinds_we;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;
   rsp_type             rsp_in;
   logic                item_is_tab;

   // item held for the whole sequence
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_data;
      end
   end

   // character classification
   assign item_is_tab       = (item_ff.char_in == CHAR_TAB);
   assign status.is_eol     = item_ff.action;
   assign status.is_space   = (item_ff.char_in == CHAR_SPACE);
   assign status.is_tab     = item_is_tab;
   assign status.is_digit   = (item_ff.char_in >= CHAR_ZERO) && (item_ff.char_in <= CHAR_NINE);
   assign status.is_digit19 = (item_ff.char_in >= CHAR_ONE) && (item_ff.char_in <= CHAR_NINE);

   // column and tab stop status
   assign status.col_at_max   = (column_ff == COL_W'(COLUMN_MAX));
   assign status.col_next_max = (column_ff == COL_W'(COLUMN_MAX - 1));
   assign status.col_lt_cont  = (column_ff < COL_W'(CONT_COLUMN));
   assign status.col_lt_stop  = (column_ff < COL_W'(TAB_STOP));
   assign status.tab_done     = (col_mod_ff == MOD_W'(TAB_STOP - 1)) || status.col_next_max;
   assign status.fto          = fto_ff;

   // blank run status
   assign status.run_empty  = (run_count_ff == '0);
   assign status.run_full   = (run_count_ff == CNT_W'(RUN_DEPTH));
   assign status.flush_done = (CNT_W'(flush_idx_ff) == run_count_ff - CNT_W'(1));

   // line state; column saturates, col_mod_ff follows column modulo the tab stop
   always_ff @(posedge clock) begin
      if (reset || cmd.line_reset) begin
         column_ff    <= '0;
         col_mod_ff   <= '0;
         fto_ff       <= 1'b1;
         run_count_ff <= '0;
         overflow_ff  <= 1'b0;
      end else begin
         if (cmd.col_inc && !status.col_at_max) begin
            column_ff  <= column_ff + COL_W'(1);
            col_mod_ff <= (col_mod_ff == MOD_W'(TAB_STOP - 1)) ? '0 : col_mod_ff + MOD_W'(1);
         end
         if (cmd.fto_clr) begin
            fto_ff <= 1'b0;
         end
         priority if (cmd.run_restart) begin
            run_count_ff <= CNT_W'(1);
            overflow_ff  <= 1'b1;
         end else if (cmd.run_clear) begin
            run_count_ff <= '0;
         end else if (cmd.run_push) begin
            run_count_ff <= run_count_ff + CNT_W'(1);
         end
      end
   end

   // flush read pointer
   always_ff @(posedge clock) begin
      if (cmd.flush_start) begin
         flush_idx_ff <= '0;
      end else if (cmd.flush_step) begin
         flush_idx_ff <= flush_idx_ff + IDX_W'(1);
      end
   end

   // run memory addressing; reads one entry ahead while flushing
   assign kinds_we = cmd.run_push || cmd.run_restart;
   assign wr_addr  = cmd.run_restart ? '0 : run_count_ff[IDX_W-1:0];

   always_comb begin
      if (!cmd.flush_active) begin
         rd_addr = '0;
      end else if (cmd.flush_step && !status.flush_done) begin
         rd_addr = flush_idx_ff + IDX_W'(1);
      end else begin
         rd_addr = flush_idx_ff;
      end
   end

   // blank kind memory, 1 = tab
   always_ff @(posedge clock) begin
      if (kinds_we) begin
         kinds_mem[wr_addr] <= item_is_tab;
      end
      kinds_rd_ff <= kinds_mem[rd_addr];
   end

   // next result
   always_comb begin
      rsp_in             = '0;
      rsp_in.last_of_run = cmd.last;
      unique case (cmd.kind)
         EMIT_SPACE: begin
            rsp_in.char_out   = CHAR_SPACE;
            rsp_in.char_valid = 1'b1;
         end
         EMIT_ITEM: begin
            rsp_in.char_out   = item_ff.char_in;
            rsp_in.char_valid = 1'b1;
         end
         EMIT_BLANK: begin
            rsp_in.char_out   = kinds_rd_ff ? CHAR_TAB : CHAR_SPACE;
            rsp_in.char_valid = 1'b1;
         end
         EMIT_END: begin
            rsp_in.line_end     = 1'b1;
            rsp_in.run_overflow = overflow_ff;
         end
         default: begin
            rsp_in.char_valid = 1'b0;
         end
      endcase
   end

   // result register
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ src/fflte_ctrl.sv @@
// controller: line phase and the per-item result sequencer
module fflte_ctrl import fflte_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_DISPATCH  = 9'b000000010,
      ST_LEAD      = 9'b000000100,
      ST_PAD_CONT  = 9'b000001000,
      ST_PAD_HELD  = 9'b000010000,
      ST_PAD_TAB   = 9'b000100000,
      ST_FLUSH     = 9'b001000000,
      ST_EMIT_CHAR = 9'b010000000,
      ST_CLOSE     = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   phase_type phase_ff;
   phase_type phase_in;
   logic      is_blank;

   assign is_blank  = status.is_space || status.is_tab;
   assign req_stall = reset || (state_ff != ST_IDLE);

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_LEADER;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   // sequencing
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DISPATCH;
            end
         end

         // pick the path for the held item
         ST_DISPATCH: begin
            cmd.flush_start = 1'b1;
            priority if (phase_ff == PH_PENDING) begin
               phase_in = PH_LEADER;
               if (!status.is_eol && status.is_digit19) begin
                  state_in = ST_PAD_CONT;
               end else begin
                  state_in = ST_PAD_HELD;
               end
            end else if (status.is_eol) begin
               state_in = ST_CLOSE;
            end else if (phase_ff == PH_TEXT) begin
               if (is_blank) begin
                  if (status.run_full) begin
                     state_in = ST_FLUSH;
                  end else begin
                     cmd.run_push = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end else if (status.run_empty) begin
                  state_in = ST_EMIT_CHAR;
               end else begin
                  state_in = ST_FLUSH;
               end
            end else begin
               phase_in = PH_LEADER;
               state_in = ST_LEAD;
            end
         end

         // leading part character
         ST_LEAD: begin
            if (status.is_tab) begin
               cmd.fto_clr = 1'b1;
               if (status.fto && status.col_lt_stop) begin
                  phase_in = PH_PENDING;
                  state_in = ST_IDLE;
               end else if (status.col_at_max) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_PAD_TAB;
               end
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = EMIT_ITEM;
               cmd.last = 1'b1;
               if (status.is_space || status.is_digit) begin
                  cmd.col_inc = 1'b1;
                  cmd.fto_clr = status.is_digit;
               end else begin
                  phase_in = PH_TEXT;
               end
               state_in = ST_IDLE;
            end
         end

         // continuation tab pads to the marker column, a digit follows
         ST_PAD_CONT: begin
            if (!status.col_lt_cont) begin
               state_in = ST_LEAD;
            end else if (status.out_free) begin
               cmd.emit    = 1'b1;
               cmd.kind    = EMIT_SPACE;
               cmd.col_inc = 1'b1;
            end
         end

         // held tab expands to the next stop, then the item itself
         ST_PAD_HELD: begin
            if (status.col_at_max) begin
               state_in = status.is_eol ? ST_CLOSE : ST_LEAD;
            end else if (status.out_free) begin
               cmd.emit    = 1'b1;
               cmd.kind    = EMIT_SPACE;
               cmd.col_inc = 1'b1;
               cmd.last    = status.tab_done && !status.is_eol && status.is_tab &&
                             status.col_next_max;
               if (status.tab_done) begin
                  state_in = status.is_eol ? ST_CLOSE : ST_LEAD;
               end
            end
         end

         // ordinary leading tab
         ST_PAD_TAB: begin
            if (status.out_free) begin
               cmd.emit    = 1'b1;
               cmd.kind    = EMIT_SPACE;
               cmd.col_inc = 1'b1;
               cmd.last    = status.tab_done;
               if (status.tab_done) begin
                  state_in = ST_IDLE;
               end
            end
         end

         // release the buffered blank run
         ST_FLUSH: begin
            cmd.flush_active = 1'b1;
            if (status.out_free) begin
               cmd.emit       = 1'b1;
               cmd.kind       = EMIT_BLANK;
               cmd.flush_step = 1'b1;
               cmd.last       = status.flush_done && is_blank;
               if (status.flush_done) begin
                  if (is_blank) begin
                     cmd.run_restart = 1'b1;
                     state_in        = ST_IDLE;
                  end else begin
                     cmd.run_clear = 1'b1;
                     state_in      = ST_EMIT_CHAR;
                  end
               end
            end
         end

         ST_EMIT_CHAR: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = EMIT_ITEM;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end

         // line end result, then back to the start of a line
         ST_CLOSE: begin
            if (status.out_free) begin
               cmd.emit       = 1'b1;
               cmd.kind       = EMIT_END;
               cmd.last       = 1'b1;
               cmd.line_reset = 1'b1;
               phase_in       = PH_LEADER;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ src/fixed_form_leader_tab_expander_top.sv @@
// top level of the fixed-form leader tab expander
// Takes one character (or end of line) per transfer and emits the expanded line as one
// result per output transfer. The block takes one item at a time: an item is taken in,
// then decoded, then the single result sequencer emits its results in turn, holding while
// the output is stalled; a buffered blank is taken in and decoded and produces nothing.
// Some items also pass through the leader state: a leading tab before its padding, a
// continuation pad whose digit the leader state emits, a tab after a resolved held tab,
// and a held tab or a tab at the column limit, which give no result. The blank run
// buffer holds up to RUN_DEPTH entries in a small memory with no reset and no clearing pass;
// a run is replayed one entry per cycle while the output is not stalled. A tab in the
// first columns is held until the next item shows whether it marks a continuation line.
module fixed_form_leader_tab_expander_top import fflte_pkg::*; #(
   parameter int RUN_DEPTH  = 63,
   parameter int COLUMN_MAX = 255
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   // controller
   fflte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   fflte_datapath #(
      .RUN_DEPTH  (RUN_DEPTH),
      .COLUMN_MAX (COLUMN_MAX)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

@@ src/fflte_checker.sv @@
// port-level checks for the leader tab expander, bound to the top level
module fflte_checker import fflte_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // one item at a time: the cycle after a transfer in is always stalled
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while an item is in progress");

   // a result without a character is exactly a line end, and it ends its item
   a_end_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.char_valid |-> rsp_data.line_end && rsp_data.last_of_run &&
      (rsp_data.char_out == '0))
      else $error("malformed line end result");

   // overflow flag only on the line end, which carries no character
   a_ovf_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.run_overflow || rsp_data.line_end) |->
      rsp_data.line_end && !rsp_data.char_valid)
      else $error("overflow flag or line end on a character result");

endmodule

bind fixed_form_leader_tab_expander_top fflte_checker u_fflte_checker (.*);

@@ dv/fixed_form_leader_tab_expander_top_tb.sv @@
// self-checking testbench for the fixed-form leader tab expander
module fixed_form_leader_tab_expander_top_tb;
   import fflte_pkg::*;

   localparam int RUN_DEPTH   = 63;
   localparam int COLUMN_MAX  = 255;
   localparam int MAX_RESULTS = 64;
   localparam int ITEM_TARGET = 280;
   localparam logic ACT_CHAR  = 1'b0;
   localparam logic ACT_EOL   = 1'b1;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   fixed_form_leader_tab_expander_top #(
      .RUN_DEPTH  (RUN_DEPTH),
      .COLUMN_MAX (COLUMN_MAX)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // expected output characters and line ends, oldest first
   rsp_type expected_out[$];
   int      mismatch_count = 0;
   int      items_sent = 0;
   int      burst_left = 0;
   int      item_results;

   // line state of the expander model
   phase_type line_phase;
   int        cur_column;
   logic      first_tab_free;
   logic      held_blanks [RUN_DEPTH];
   int        held_count;
   logic      run_overflowed;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // expander model
   // ------------------------------------------------------------------

   function automatic void emit(logic [CHAR_W-1:0] ch, logic valid, logic eol, logic ovf);
      rsp_type r;
      if (item_results >= MAX_RESULTS) return;
      r.char_out     = valid ? ch : '0;
      r.char_valid   = valid;
      r.line_end     = eol;
      r.run_overflow = ovf;
      r.last_of_run  = 1'b0;
      expected_out.push_back(r);
      item_results++;
   endfunction

   function automatic void restart_line();
      line_phase     = PH_LEADER;
      cur_column     = 0;
      first_tab_free = 1'b1;
      held_count     = 0;
      run_overflowed = 1'b0;
   endfunction

   function automatic void pad_to(int target);
      if (target > COLUMN_MAX) target = COLUMN_MAX;
      while (cur_column < target) begin
         emit(CHAR_SPACE, 1'b1, 1'b0, 1'b0);
         cur_column++;
      end
   endfunction

   function automatic void tab_pad();
      pad_to((cur_column / TAB_STOP) * TAB_STOP + TAB_STOP);
   endfunction

   function automatic void bump_column();
      if (cur_column < COLUMN_MAX) cur_column++;
   endfunction

   function automatic void close_line();
      emit('0, 1'b0, 1'b1, run_overflowed);
      restart_line();
   endfunction

   function automatic void flush_held();
      for (int i = 0; i < held_count; i++)
         emit(held_blanks[i] ? CHAR_TAB : CHAR_SPACE, 1'b1, 1'b0, 1'b0);
      held_count = 0;
   endfunction

   function automatic void leader_char(logic [CHAR_W-1:0] c);
      if (c == CHAR_SPACE) begin
         emit(c, 1'b1, 1'b0, 1'b0);
         bump_column();
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         emit(c, 1'b1, 1'b0, 1'b0);
         bump_column();
         first_tab_free = 1'b0;
      end else if (c == CHAR_TAB) begin
         // only the first tab in the first columns may mark a continuation
         if (first_tab_free && cur_column < TAB_STOP) begin
            first_tab_free = 1'b0;
            line_phase = PH_PENDING;
         end else begin
            first_tab_free = 1'b0;
            tab_pad();
         end
      end else begin
         line_phase = PH_TEXT;
         emit(c, 1'b1, 1'b0, 1'b0);
      end
   endfunction

   function automatic void text_char(logic [CHAR_W-1:0] c);
      if (c == CHAR_SPACE || c == CHAR_TAB) begin
         // full run buffer goes out early
         if (held_count >= RUN_DEPTH) begin
            flush_held();
            run_overflowed = 1'b1;
         end
         held_blanks[held_count] = (c == CHAR_TAB);
         held_count++;
      end else begin
         flush_held();
         emit(c, 1'b1, 1'b0, 1'b0);
      end
   endfunction

   function automatic void expand_item(req_type it);
      logic              eol;
      logic [CHAR_W-1:0] c;
      rsp_type           tail;
      eol = it.action;
      c = it.char_in;
      item_results = 0;
      if (line_phase == PH_PENDING) begin
         // held tab resolved by this item
         line_phase = PH_LEADER;
         if (!eol && c >= CHAR_ONE && c <= CHAR_NINE) begin
            pad_to(CONT_COLUMN);
            leader_char(c);
         end else begin
            tab_pad();
            if (eol) close_line();
            else leader_char(c);
         end
      end else if (eol) begin
         close_line();
      end else if (line_phase == PH_TEXT) begin
         text_char(c);
      end else begin
         line_phase = PH_LEADER;
         leader_char(c);
      end
      // mark the final result of this item
      if (item_results > 0) begin
         tail = expected_out.pop_back();
         tail.last_of_run = 1'b1;
         expected_out.push_back(tail);
      end
   endfunction

   // ------------------------------------------------------------------
   // input side
   // ------------------------------------------------------------------

   // one input transfer, in bursts with random gaps
   task automatic send_item(input logic act, input logic [CHAR_W-1:0] ch);
      req_type item;
      int      gap;
      item.action  = act;
      item.char_in = ch;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      items_sent++;
      expand_item(item);
   endtask

   task automatic send_eol();
      send_item(ACT_EOL, CHAR_W'($urandom_range(0, 255)));
   endtask

   task automatic send_line(input string s);
      for (int i = 0; i < s.len(); i++) send_item(ACT_CHAR, s[i]);
      send_eol();
   endtask

   task automatic send_blanks(input int n);
      for (int i = 0; i < n; i++)
         send_item(ACT_CHAR, $urandom_range(0, 1) ? CHAR_TAB : CHAR_SPACE);
   endtask

   task automatic send_digit(input int lo);
      send_item(ACT_CHAR, CHAR_ZERO + CHAR_W'($urandom_range(lo, 9)));
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // empty lines, leader only lines, trailing blanks and extreme bytes
   task automatic test_plain_lines();
      send_line("");
      send_line(" 12 0");
      send_line("  x = 1 \t ");
      send_line("ab \t c");
      send_item(ACT_CHAR, 8'hFF);
      send_item(ACT_CHAR, 8'h00);
      send_item(ACT_CHAR, 8'h80);
      send_item(ACT_CHAR, CHAR_SPACE);
      send_item(ACT_CHAR, 8'h7F);
      send_item(ACT_EOL, 8'hFF);
      send_item(ACT_EOL, 8'h00);
   endtask

   // continuation tab and the held tab resolved every way
   task automatic test_continuation_tab();
      send_line("\t1abc");
      send_line("12\t3x");
      send_line("\t");
      send_line("\tA");
      send_line("\t0y");
      send_line("     \t9");
      send_line("      \t1");
      send_line("1\t\t2");
      send_line("\t \t5z");
   endtask

   // column held at its maximum in a long leader
   task automatic test_column_limit();
      for (int i = 0; i < 45; i++) send_item(ACT_CHAR, CHAR_TAB);
      send_item(ACT_CHAR, CHAR_SPACE);
      send_item(ACT_CHAR, CHAR_NINE);
      send_item(ACT_CHAR, CHAR_TAB);
      send_eol();
   endtask

   // blank run beyond the buffer depth, then text
   task automatic test_blank_run_overflow();
      send_item(ACT_CHAR, "x");
      send_blanks(RUN_DEPTH + 1);
      send_item(ACT_CHAR, "y");
      send_eol();
   endtask

   // random lines: leader, text tokens and blank runs
   task automatic send_random_line();
      int n_lead;
      int n_tok;
      int r;
      if ($urandom_range(0, 9) == 0)
         for (int i = $urandom_range(40, 46); i > 0; i--) send_item(ACT_CHAR, CHAR_TAB);
      if ($urandom_range(0, 3) == 0) begin
         for (int i = $urandom_range(0, 3); i > 0; i--) send_digit(0);
         send_item(ACT_CHAR, CHAR_TAB);
         send_digit(1);
      end
      n_lead = $urandom_range(0, 7);
      for (int i = 0; i < n_lead; i++) begin
         r = $urandom_range(0, 9);
         if (r < 3) send_item(ACT_CHAR, CHAR_SPACE);
         else if (r < 6) send_digit(0);
         else if (r < 9) send_item(ACT_CHAR, CHAR_TAB);
         else send_item(ACT_CHAR, CHAR_W'($urandom_range(0, 255)));
      end
      n_tok = $urandom_range(0, 8);
      for (int i = 0; i < n_tok; i++) begin
         r = $urandom_range(0, 19);
         if (r == 0) send_blanks($urandom_range(RUN_DEPTH - 3, RUN_DEPTH + 7));
         else if (r < 8) send_blanks($urandom_range(1, 4));
         else if (r < 17) send_item(ACT_CHAR, CHAR_W'($urandom_range(33, 126)));
         else send_item(ACT_CHAR, CHAR_W'($urandom_range(0, 255)));
      end
      send_eol();
   endtask

   // random lines until the item budget is used
   task automatic test_random_lines();
      while (items_sent < ITEM_TARGET) send_random_line();
   endtask

   // ------------------------------------------------------------------
   // output side
   // ------------------------------------------------------------------

   // receiver stall pattern, changing its density now and then
   initial begin
      int stall_pct;
      rsp_stall = 1'b0;
      forever begin
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 50;
            default: stall_pct = 85;
         endcase
         repeat ($urandom_range(10, 60)) begin
            @(negedge clock);
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   function automatic void note_mismatch(string what, rsp_type want, rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch (%s): expected %h/%b%b%b%b got %h/%b%b%b%b",
                  what, want.char_out, want.char_valid, want.line_end, want.run_overflow,
                  want.last_of_run, got.char_out, got.char_valid, got.line_end,
                  got.run_overflow, got.last_of_run);
   endfunction

   // compare each output transfer with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_out.size() == 0) begin
            note_mismatch("unexpected", '0, rsp_data);
         end else begin
            want = expected_out.pop_front();
            if (want.char_out !== rsp_data.char_out ||
                want.char_valid !== rsp_data.char_valid ||
                want.line_end !== rsp_data.line_end ||
                want.run_overflow !== rsp_data.run_overflow ||
                want.last_of_run !== rsp_data.last_of_run)
               note_mismatch("field", want, rsp_data);
         end
      end
   end

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      restart_line();
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      test_plain_lines();
      test_continuation_tab();
      test_column_limit();
      test_blank_run_overflow();
      test_random_lines();

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_out.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_out.size() == 0)
         $display("[fixed_form_leader_tab_expander_top] OK");
      else
         $display("[fixed_form_leader_tab_expander_top] ERROR");
      $finish;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("[fixed_form_leader_tab_expander_top] ERROR");
      $finish;
   end

endmodule

@@ fixed_form_leader_tab_expander_top.f @@
src/fflte_pkg.sv
src/fflte_datapath.sv
src/fflte_ctrl.sv
src/fixed_form_leader_tab_expander_top.sv
src/fflte_checker.sv
dv/fixed_form_leader_tab_expander_top_tb.sv
